FILE: rtl/fscg_pkg.sv
`default_nettype none
package fscg_pkg;
  localparam int unsigned PCT_MAX = 100;
  localparam int unsigned PCT_BITS = 7;
  localparam int unsigned OUT_BITS = 32;
  localparam int unsigned IN_TDATA_BITS = 80;
  localparam int unsigned OUT_TDATA_BITS = 136;

  function automatic logic [PCT_BITS-1:0] clamp_pct(input logic [PCT_BITS-1:0] v);
    clamp_pct = (v > PCT_BITS'(PCT_MAX)) ? PCT_BITS'(PCT_MAX) : v;
  endfunction
endpackage
`default_nettype wire

FILE: rtl/fscg_divider.sv
`default_nettype none
// pipelined restoring divider, one quotient bit per stage, carries a side payload
module fscg_divider #(
  parameter int unsigned NUM_BITS = 32,
  parameter int unsigned DEN_BITS = 16,
  parameter int unsigned SIDE_BITS = 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [NUM_BITS-1:0]  in_num,
  input  wire logic [DEN_BITS-1:0]  in_den,
  input  wire logic [SIDE_BITS-1:0] in_side,
  output logic                      out_valid,
  output logic [NUM_BITS-1:0]       out_quot,
  output logic                      out_rem_nz,
  output logic [SIDE_BITS-1:0]      out_side
);
  localparam int unsigned REM_BITS = DEN_BITS + 1;
  logic [NUM_BITS-1:0]  q_r   [NUM_BITS+1];
  logic [REM_BITS-1:0]  rem_r [NUM_BITS+1];
  logic [DEN_BITS-1:0]  den_r [NUM_BITS+1];
  logic [SIDE_BITS-1:0] side_r[NUM_BITS+1];
  logic [NUM_BITS:0]    v_r;

  always_comb begin
    q_r[0] = in_num;
    rem_r[0] = '0;
    den_r[0] = in_den;
    side_r[0] = in_side;
    v_r[0] = in_valid;
  end

  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    logic [REM_BITS-1:0] trial;
    logic                fits;
    assign trial = {rem_r[s][DEN_BITS-1:0], q_r[s][NUM_BITS-1]};
    assign fits = trial >= {1'b0, den_r[s]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= fits ? trial - {1'b0, den_r[s]} : trial;
        q_r[s+1] <= {q_r[s][NUM_BITS-2:0], fits};
        den_r[s+1] <= den_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_valid = v_r[NUM_BITS];
  assign out_quot = q_r[NUM_BITS];
  assign out_rem_nz = rem_r[NUM_BITS] != '0;
  assign out_side = side_r[NUM_BITS];
endmodule
`default_nettype wire

FILE: rtl/fill_scale_crop_geometry_unit.sv
`default_nettype none
// throughput: one transaction per cycle while the output is not held; two restoring divider pipelines set the depth
// stall: a held output stalls the whole pipeline; an empty output slot keeps it moving
// reset: rst_n synchronous active low, clears all valid bits; payload is not reset
module fill_scale_crop_geometry_unit
  import fscg_pkg::*;
#(
  parameter int unsigned DIM_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // src_width[15:0], src_height[31:16], crop_width[47:32], crop_height[63:48],
  // pos_x[70:64], pos_y[77:71], zero pad
  input  wire logic [IN_TDATA_BITS-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // scaled_width[31:0], scaled_height[63:32], offset_x[95:64], offset_y[127:96],
  // error[128], zero pad
  output logic [OUT_TDATA_BITS-1:0]       out_tdata
);
  localparam int unsigned DB = (DIM_BITS > 16) ? 16 : DIM_BITS;
  localparam int unsigned PB = 2 * DB;          // product width
  localparam int unsigned LB = PB + 1;          // scaled length width
  localparam int unsigned MB = LB + PCT_BITS;   // length times percent
  localparam int unsigned SB = LB + 2 + DB;     // side payload
  localparam logic [1:0] MODE_ZERO = 2'd0;
  localparam logic [1:0] MODE_TAIL = 2'd1;
  localparam logic [1:0] MODE_HEAD = 2'd2;
  localparam logic [1:0] MODE_SPLIT = 2'd3;

  logic en;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage 1: unpack, clamp, cross products
  logic [DB-1:0] sw, sh, cw, ch;
  assign sw = in_tdata[DB-1:0];
  assign sh = in_tdata[16 +: DB];
  assign cw = in_tdata[32 +: DB];
  assign ch = in_tdata[48 +: DB];

  logic s1_v_r;
  logic [PB-1:0] s1_a_r, s1_b_r;
  logic [DB-1:0] s1_sw_r, s1_sh_r, s1_cw_r, s1_ch_r;
  logic [PCT_BITS-1:0] s1_px_r, s1_py_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (en) s1_v_r <= in_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r <= PB'(cw) * PB'(sh);
      s1_b_r <= PB'(ch) * PB'(sw);
      s1_sw_r <= sw; s1_sh_r <= sh; s1_cw_r <= cw; s1_ch_r <= ch;
      s1_px_r <= clamp_pct(in_tdata[70:64]);
      s1_py_r <= clamp_pct(in_tdata[77:71]);
    end
  end

  // stage 2: choose fill axis, start ceiling divide
  logic fill_w, err1;
  logic [PB-1:0] d1_num;
  logic [DB-1:0] d1_den, crop_long, crop_fill;
  assign err1 = (s1_sw_r == '0) || (s1_sh_r == '0);
  assign fill_w = s1_a_r >= s1_b_r;
  assign d1_num = fill_w ? s1_a_r : s1_b_r;
  assign d1_den = fill_w ? s1_sw_r : s1_sh_r;
  assign crop_long = fill_w ? s1_ch_r : s1_cw_r;
  assign crop_fill = fill_w ? s1_cw_r : s1_ch_r;

  localparam int unsigned S1B = 2 + 2 * PCT_BITS + 2 * DB;
  logic dv1_v, dv1_rnz;
  logic [PB-1:0] dv1_q;
  logic [S1B-1:0] dv1_side;
  fscg_divider #(.NUM_BITS(PB), .DEN_BITS(DB), .SIDE_BITS(S1B)) u_scale_div (
    .clk, .rst_n, .en, .in_valid(s1_v_r), .in_num(d1_num), .in_den(d1_den),
    .in_side({err1, fill_w, s1_px_r, s1_py_r, crop_long, crop_fill}),
    .out_valid(dv1_v), .out_quot(dv1_q), .out_rem_nz(dv1_rnz), .out_side(dv1_side)
  );

  logic e2, fw2;
  logic [PCT_BITS-1:0] px2, py2;
  logic [DB-1:0] cl2, cf2;
  assign {e2, fw2, px2, py2, cl2, cf2} = dv1_side;

  // stage 3: scaled length, room, mode
  logic s3_v_r, s3_e_r, s3_fw_r;
  logic [LB-1:0] s3_len_r, s3_room_r;
  logic [DB-1:0] s3_cl_r, s3_cf_r;
  logic [PCT_BITS-1:0] s3_px_r, s3_py_r;
  logic [1:0] s3_mode_r;
  logic [LB-1:0] len2;
  assign len2 = {1'b0, dv1_q} + LB'(dv1_rnz);
  always_ff @(posedge clk) begin
    if (!rst_n) s3_v_r <= 1'b0;
    else if (en) s3_v_r <= dv1_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s3_e_r <= e2; s3_fw_r <= fw2; s3_cl_r <= cl2; s3_cf_r <= cf2;
      s3_px_r <= px2; s3_py_r <= py2;
      s3_len_r <= len2;
      s3_room_r <= (len2 >= LB'(cl2)) ? len2 - LB'(cl2) : '0;
      if (px2 == '0 && py2 == '0) s3_mode_r <= MODE_ZERO;
      else if (px2 == '0) s3_mode_r <= MODE_TAIL;
      else if (py2 == '0) s3_mode_r <= MODE_HEAD;
      else s3_mode_r <= MODE_SPLIT;
    end
  end

  // stage 4: numerator and divisor for placement
  logic s4_v_r;
  logic [MB-1:0] s4_num_r;
  logic [PCT_BITS:0] s4_den_r;
  logic [SB-1:0] s4_side_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s4_v_r <= 1'b0;
    else if (en) s4_v_r <= s3_v_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      case (s3_mode_r)
        MODE_TAIL: begin
          s4_num_r <= MB'(s3_len_r) * MB'(PCT_BITS'(PCT_MAX) - s3_py_r);
          s4_den_r <= (PCT_BITS+1)'(PCT_MAX);
        end
        MODE_HEAD: begin
          s4_num_r <= MB'(s3_len_r) * MB'(s3_px_r);
          s4_den_r <= (PCT_BITS+1)'(PCT_MAX);
        end
        MODE_SPLIT: begin
          s4_num_r <= MB'(s3_room_r) * MB'(s3_px_r);
          s4_den_r <= {1'b0, s3_px_r} + {1'b0, s3_py_r};
        end
        default: begin
          s4_num_r <= '0;
          s4_den_r <= (PCT_BITS+1)'(1);
        end
      endcase
      s4_side_r <= {s3_len_r, s3_e_r, s3_fw_r, s3_cf_r};
    end
  end

  // room and crop are needed after the divide too; carry them alongside
  logic [LB-1:0] s4_room_r;
  logic [DB-1:0] s4_cl_r;
  logic [1:0] s4_mode_r;
  always_ff @(posedge clk) begin
    if (en) begin
      s4_room_r <= s3_room_r;
      s4_cl_r <= s3_cl_r;
      s4_mode_r <= s3_mode_r;
    end
  end

  localparam int unsigned S2B = SB + LB + DB + 2;
  logic dv2_v, dv2_rnz;
  logic [MB-1:0] dv2_q;
  logic [S2B-1:0] dv2_side;
  fscg_divider #(.NUM_BITS(MB), .DEN_BITS(PCT_BITS+1), .SIDE_BITS(S2B)) u_place_div (
    .clk, .rst_n, .en, .in_valid(s4_v_r), .in_num(s4_num_r), .in_den(s4_den_r),
    .in_side({s4_side_r, s4_room_r, s4_cl_r, s4_mode_r}),
    .out_valid(dv2_v), .out_quot(dv2_q), .out_rem_nz(dv2_rnz), .out_side(dv2_side)
  );

  logic [LB-1:0] len5, room5;
  logic e5, fw5;
  logic [DB-1:0] cf5, cl5;
  logic [1:0] mode5;
  assign {len5, e5, fw5, cf5, room5, cl5, mode5} = dv2_side;

  // stage 5: finish placement, build result
  logic [MB-1:0] off;
  always_comb begin
    case (mode5)
      MODE_TAIL: off = dv2_q - ((dv2_q < MB'(cl5)) ? dv2_q : MB'(cl5));
      MODE_HEAD: off = (dv2_q < MB'(room5)) ? dv2_q : MB'(room5);
      MODE_SPLIT: off = dv2_q;
      default: off = '0;
    endcase
  end

  logic [OUT_BITS-1:0] w5, h5, ox5, oy5;
  always_comb begin
    w5 = '0; h5 = '0; ox5 = '0; oy5 = '0;
    if (!e5) begin
      if (fw5) begin
        w5 = OUT_BITS'(cf5); h5 = OUT_BITS'(len5); oy5 = OUT_BITS'(off);
      end else begin
        h5 = OUT_BITS'(cf5); w5 = OUT_BITS'(len5); ox5 = OUT_BITS'(off);
      end
    end
  end

  logic out_v_r;
  logic [OUT_TDATA_BITS-1:0] out_d_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else if (en) out_v_r <= dv2_v;
  end
  always_ff @(posedge clk) begin
    if (en) out_d_r <= {7'b0, e5, oy5, ox5, h5, w5};
  end
  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;

  // remainder of the placement divide would only matter for a ceiling; placement takes the floor, so unused
  logic unused_ok;
  assign unused_ok = dv2_rnz;

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[128] |-> out_tdata[127:0] == '0) else $error("error not zeroed");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("stall lost");
  a_fill_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[95:64] == '0 || out_tdata[127:96] == '0) else $error("two offsets");
`endif
endmodule
`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
module tb;
  import fscg_pkg::*;

  typedef struct packed {
    logic [6:0]  pos_y;
    logic [6:0]  pos_x;
    logic [15:0] crop_height;
    logic [15:0] crop_width;
    logic [15:0] src_height;
    logic [15:0] src_width;
  } geom_req_t;

  typedef struct packed {
    logic        error;
    logic [31:0] offset_y;
    logic [31:0] offset_x;
    logic [31:0] scaled_height;
    logic [31:0] scaled_width;
  } geom_res_t;

  localparam int LATENCY = 76;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 450;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [135:0] out_tdata;

  geom_req_t pending_reqs[$];
  geom_res_t expected_geoms[$];
  int errors = 0;
  bit stim_done = 1'b0;
  bit quiet_tail = 1'b0;
  int hold_off_cycles = 0;
  bit hold_off_started = 1'b0;
  int gap_in = 0;
  int gap_out = 0;
  int idle_cycles = 0;

  fill_scale_crop_geometry_unit #(.DIM_BITS(16)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // crop offset along the long axis
  function automatic logic [63:0] crop_offset(logic [63:0] len, logic [63:0] crop,
                                              logic [63:0] px, logic [63:0] py);
    logic [63:0] room, t;
    room = (len >= crop) ? len - crop : 64'd0;
    if (px == 0 && py == 0) return 64'd0;
    if (px == 0) begin
      t = len * (100 - py) / 100;
      return t - ((t < crop) ? t : crop);
    end
    if (py == 0) begin
      t = len * px / 100;
      return (t < room) ? t : room;
    end
    return room * px / (px + py);
  endfunction

  function automatic geom_res_t fill_crop_geometry(geom_req_t r);
    geom_res_t res;
    logic [63:0] sw, sh, cw, ch, px, py, p, w, h, ox, oy;
    sw = r.src_width; sh = r.src_height; cw = r.crop_width; ch = r.crop_height;
    px = (r.pos_x > 100) ? 64'd100 : 64'(r.pos_x);
    py = (r.pos_y > 100) ? 64'd100 : 64'(r.pos_y);
    w = 0; h = 0; ox = 0; oy = 0;
    res = '0;
    if (sw == 0 || sh == 0) begin
      res.error = 1'b1;
    end else if (cw * sh >= ch * sw) begin
      // width fills, height scaled up with ceiling
      w = cw;
      p = cw * sh;
      h = p / sw + ((p % sw != 0) ? 1 : 0);
      oy = crop_offset(h, ch, px, py);
    end else begin
      h = ch;
      p = ch * sw;
      w = p / sh + ((p % sh != 0) ? 1 : 0);
      ox = crop_offset(w, cw, px, py);
    end
    res.scaled_width = w[31:0];
    res.scaled_height = h[31:0];
    res.offset_x = ox[31:0];
    res.offset_y = oy[31:0];
    return res;
  endfunction

  function automatic logic [15:0] rand_dim();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hFFFF - 16'($urandom_range(0, 3));
      2: return 16'($urandom_range(1, 64));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] rand_pct();
    case ($urandom_range(0, 3))
      0: return 7'd0;
      1: return 7'($urandom_range(101, 127));
      default: return 7'($urandom_range(0, 100));
    endcase
  endfunction

  task automatic add_req(logic [15:0] sw, logic [15:0] sh, logic [15:0] cw,
                         logic [15:0] ch, logic [6:0] px, logic [6:0] py);
    geom_req_t r;
    r.src_width = sw; r.src_height = sh; r.crop_width = cw; r.crop_height = ch;
    r.pos_x = px; r.pos_y = py;
    pending_reqs.push_back(r);
  endtask

  // stimulus: directed corners, then random requests
  initial begin
    add_req(16'd0, 16'd100, 16'd50, 16'd50, 7'd10, 7'd20);       // zero source width
    add_req(16'd100, 16'd0, 16'd50, 16'd50, 7'd10, 7'd20);       // zero source height
    add_req(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 7'h7F, 7'h7F);
    add_req(16'd1920, 16'd1080, 16'd300, 16'd300, 7'd0, 7'd0);   // both positions zero
    add_req(16'd1920, 16'd1080, 16'd300, 16'd300, 7'd0, 7'd30);  // only pos_y
    add_req(16'd1920, 16'd1080, 16'd300, 16'd300, 7'd40, 7'd0);  // only pos_x
    add_req(16'd1920, 16'd1080, 16'd300, 16'd300, 7'd25, 7'd75); // split ratio
    add_req(16'd1080, 16'd1920, 16'd300, 16'd300, 7'd0, 7'd100);
    add_req(16'd1080, 16'd1920, 16'd300, 16'd300, 7'd100, 7'd0);
    add_req(16'd1080, 16'd1920, 16'd300, 16'd300, 7'd127, 7'd127); // clamped
    add_req(16'd1080, 16'd1920, 16'd300, 16'd300, 7'd101, 7'd0);
    add_req(16'd1920, 16'd1080, 16'd0, 16'd0, 7'd50, 7'd50);     // zero crop size
    add_req(16'd1920, 16'd1080, 16'd0, 16'd200, 7'd50, 7'd0);
    add_req(16'd1920, 16'd1080, 16'd200, 16'd0, 7'd0, 7'd50);
    add_req(16'hFFFF, 16'd1, 16'd1, 16'hFFFF, 7'd50, 7'd50);     // extreme scaling
    add_req(16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 7'd99, 7'd1);
    add_req(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'd100, 7'd100);
    add_req(16'd1, 16'd1, 16'd1, 16'd1, 7'd1, 7'd0);
    add_req(16'd3, 16'd7, 16'd5, 16'd11, 7'd33, 7'd67);
    add_req(16'd7, 16'd3, 16'd11, 16'd5, 7'd0, 7'd1);
    for (int i = 0; i < N_RANDOM; i++) begin
      add_req(rand_dim(), rand_dim(), rand_dim(), rand_dim(), rand_pct(), rand_pct());
    end
  end

  // reset
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_geoms.push_back(fill_crop_geometry(geom_req_t'(in_tdata[77:0])));
        void'(pending_reqs.pop_front());
      end
      quiet_tail <= pending_reqs.size() < 60;
      if (gap_in > 0) begin
        gap_in <= gap_in - 1;
        in_tvalid <= 1'b0;
      end else if (!(in_tvalid && !in_tready) && !quiet_tail &&
                   $urandom_range(0, 7) == 0) begin
        // random idle burst on the sender side
        gap_in <= $urandom_range(0, 2);
        in_tvalid <= 1'b0;
      end else if (in_tvalid && !in_tready) begin
        in_tvalid <= 1'b1;
      end else if (pending_reqs.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {2'b00, pending_reqs[0]};
      end else begin
        in_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // receiver backpressure
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_off_started && expected_geoms.size() > 10) begin
        // one long hold so the pipeline fills and in_tready drops
        hold_off_started <= 1'b1;
        hold_off_cycles <= 150;
        out_tready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
        hold_off_cycles <= hold_off_cycles - 1;
        out_tready <= 1'b0;
      end else if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_tready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        gap_out <= $urandom_range(0, 2);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    geom_res_t got, exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      got = geom_res_t'(out_tdata[128:0]);
      if (expected_geoms.size() == 0) begin
        $error("unexpected result transaction %h", out_tdata);
        errors++;
      end else begin
        exp_res = expected_geoms.pop_front();
        if (got.scaled_width !== exp_res.scaled_width) begin
          $error("scaled_width expected %0d actual %0d", exp_res.scaled_width,
                 got.scaled_width);
          errors++;
        end
        if (got.scaled_height !== exp_res.scaled_height) begin
          $error("scaled_height expected %0d actual %0d", exp_res.scaled_height,
                 got.scaled_height);
          errors++;
        end
        if (got.offset_x !== exp_res.offset_x) begin
          $error("offset_x expected %0d actual %0d", exp_res.offset_x, got.offset_x);
          errors++;
        end
        if (got.offset_y !== exp_res.offset_y) begin
          $error("offset_y expected %0d actual %0d", exp_res.offset_y, got.offset_y);
          errors++;
        end
        if (got.error !== exp_res.error) begin
          $error("error expected %0d actual %0d", exp_res.error, got.error);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (expected_geoms.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && expected_geoms.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
